>>> rtl/lplt_pkg.sv
// Shared constants, types and codes of the linear probe layout table.
// Depends on nothing; the probe sequencer, the top level and the testbench import it.
package lplt_pkg;

	localparam int TABLE_SLOTS         = 1024;
	localparam int MAX_INLINE_POINTERS = 16;

	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int KEY_W  = 64;
	localparam int SIZE_W = 32;
	localparam int PTRT_W = 16;
	localparam int PTR_W  = 5;

	localparam logic [PTRT_W-1:0] MAX_PTRS = PTRT_W'(MAX_INLINE_POINTERS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_UPDATED   = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4,
		ST_RESERVED  = 3'd5
	} status_t;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_LOOKUP = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		PS_CLEAR,
		PS_IDLE,
		PS_PROBE
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] size;
		logic [PTR_W-1:0]  ptrs;
	} slot_t;

	localparam int ROW_W = $bits(slot_t);

	typedef struct packed {
		logic              valid;
		status_t           status;
		logic [SIZE_W-1:0] size;
		logic [PTR_W-1:0]  ptrs;
	} res_t;

endpackage

>>> rtl/linear_probe_layout_table.sv
// Top level of the linear probe layout table: slot memory, probe sequencer and
// output register. Depends on lplt_pkg, lplt_slot_ram and lplt_probe_ctrl.
//
//   channel   handshake              payload
//   input     in_valid / in_stall    action, type_key, object_size, pointer_total
//   output    out_valid / out_stall  status, found_size, found_pointers
//
// A beat with the reserved key has its result registered at the edge that accepts it.
// Any other beat probes its chain with one slot memory read a cycle, so its result is
// registered after between one and TABLE_SLOTS slots have been read; no new beat is
// accepted while a probe is in progress.
// After reset a clearing pass writes every slot with in_stall high. A result held
// by out_stall keeps the finishing probe waiting.
module linear_probe_layout_table
	import lplt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic [KEY_W-1:0]  type_key,
	input  logic [SIZE_W-1:0] object_size,
	input  logic [PTRT_W-1:0] pointer_total,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic [SIZE_W-1:0] found_size,
	output logic [PTR_W-1:0]  found_pointers
);

	res_t              res;
	logic              out_free;
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	slot_t             ram_wdata;
	logic              ram_re;
	logic [SLOT_W-1:0] ram_raddr;
	slot_t             ram_rdata;
	logic              out_valid_q;
	status_t           status_q;
	logic [SIZE_W-1:0] size_q;
	logic [PTR_W-1:0]  ptrs_q;

	assign out_free = !out_valid_q || !out_stall;

	lplt_slot_ram #(
		.DATA_W (ROW_W),
		.DEPTH  (TABLE_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lplt_probe_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.type_key      (type_key),
		.object_size   (object_size),
		.pointer_total (pointer_total),
		.out_free      (out_free),
		.res           (res),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			status_q <= res.status;
			size_q   <= res.size;
			ptrs_q   <= res.ptrs;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found_size     = size_q;
	assign found_pointers = ptrs_q;

endmodule

>>> rtl/lplt_slot_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and appears in the cycle after the read enable.
module lplt_slot_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/lplt_probe_ctrl.sv
// Probe sequencer: clears the slot memory after reset, then walks the probe chain of
// each nonzero-key beat one slot per cycle and writes back inserts and updates. Uses lplt_pkg.
module lplt_probe_ctrl
	import lplt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic [KEY_W-1:0]  type_key,
	input  logic [SIZE_W-1:0] object_size,
	input  logic [PTRT_W-1:0] pointer_total,
	input  logic              out_free,
	output res_t              res,
	output logic              ram_we,
	output logic [SLOT_W-1:0] ram_waddr,
	output slot_t             ram_wdata,
	output logic              ram_re,
	output logic [SLOT_W-1:0] ram_raddr,
	input  slot_t             ram_rdata
);

	state_t            state_q, state_d;
	logic [SLOT_W-1:0] clr_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] cnt_q;
	action_t           action_q;
	logic [KEY_W-1:0]  key_q;
	logic [SIZE_W-1:0] size_q;
	logic [PTR_W-1:0]  ptrs_q;

	logic accept;
	logic key_zero;
	logic hit_empty;
	logic hit_key;
	logic last_probe;
	logic done;
	logic [PTRT_W-1:0] clamped;

	assign key_zero   = (type_key == '0);
	assign accept     = in_valid && !in_stall;
	assign hit_empty  = (ram_rdata.key == '0);
	assign hit_key    = (ram_rdata.key == key_q);
	assign last_probe = (cnt_q == LAST_SLOT);
	assign done       = hit_empty || hit_key || last_probe;
	assign clamped    = (pointer_total > MAX_PTRS) ? MAX_PTRS : pointer_total;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PS_CLEAR: begin
				if (clr_q == LAST_SLOT) begin
					state_d = PS_IDLE;
				end
			end
			PS_IDLE: begin
				if (accept && !key_zero) begin
					state_d = PS_PROBE;
				end
			end
			PS_PROBE: begin
				if (done && out_free) begin
					state_d = PS_IDLE;
				end
			end
			default: state_d = PS_CLEAR;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		res        = '0;
		res.status = ST_INSERTED;
		ram_we     = 1'b0;
		ram_waddr  = idx_q;
		ram_wdata  = '{key: key_q, size: size_q, ptrs: ptrs_q};
		ram_re     = 1'b0;
		ram_raddr  = idx_q + 1'b1;
		unique case (state_q)
			PS_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			PS_IDLE: begin
				in_stall  = key_zero && !out_free;
				ram_raddr = type_key[SLOT_W-1:0];
				if (accept) begin
					if (key_zero) begin
						res.valid  = 1'b1;
						res.status = ST_RESERVED;
					end else begin
						ram_re = 1'b1;
					end
				end
			end
			PS_PROBE: begin
				if (!done) begin
					ram_re = 1'b1;
				end else if (out_free) begin
					res.valid = 1'b1;
					if (action_q == ACT_INSERT) begin
						if (hit_empty || hit_key) begin
							ram_we     = 1'b1;
							res.status = hit_empty ? ST_INSERTED : ST_UPDATED;
						end else begin
							res.status = ST_FULL;
						end
					end else if (hit_key && !hit_empty) begin
						res.status = ST_FOUND;
						res.size   = ram_rdata.size;
						res.ptrs   = ram_rdata.ptrs;
					end else begin
						res.status = ST_NOT_FOUND;
					end
				end
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_CLEAR;
			clr_q   <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == PS_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == PS_IDLE && accept && !key_zero) begin
				idx_q <= type_key[SLOT_W-1:0];
				cnt_q <= '0;
			end else if (state_q == PS_PROBE && !done) begin
				idx_q <= idx_q + 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == PS_IDLE && accept) begin
			action_q <= action_t'(action);
			key_q    <= type_key;
			size_q   <= object_size;
			ptrs_q   <= clamped[PTR_W-1:0];
		end
	end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the linear probe layout table: random and directed
// inserts and lookups, checked against a shadow copy of the slot table.
// Depends on lplt_pkg and linear_probe_layout_table from the rtl folder.
module testbench;
	import lplt_pkg::*;

	localparam int POOL_KEYS     = 200;
	localparam int RANDOM_BEATS  = 1150;
	localparam int FULL_BEATS    = 30;
	localparam int SETTLE_CYCLES = TABLE_SLOTS + 64;
	localparam int CYCLE_LIMIT   = 16_000_000;

	typedef struct {
		action_t           act;
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] size;
		logic [PTRT_W-1:0] ptot;
		bit                hold;
	} layout_req_t;

	typedef struct {
		status_t           status;
		logic [SIZE_W-1:0] size;
		logic [PTR_W-1:0]  ptrs;
	} layout_reply_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              action = 1'b0;
	logic [KEY_W-1:0]  type_key = '0;
	logic [SIZE_W-1:0] object_size = '0;
	logic [PTRT_W-1:0] pointer_total = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [2:0]        status;
	logic [SIZE_W-1:0] found_size;
	logic [PTR_W-1:0]  found_pointers;

	bit [KEY_W-1:0]  shadow_key  [TABLE_SLOTS];
	bit [SIZE_W-1:0] shadow_size [TABLE_SLOTS];
	bit [PTR_W-1:0]  shadow_ptrs [TABLE_SLOTS];
	bit              keys_used [bit [KEY_W-1:0]];

	layout_req_t   pending [$];
	layout_reply_t replies_due [$];
	int            beats_loaded = 0;
	int            results_seen = 0;
	int            fail_count = 0;
	int            status_hits [6];
	int            cycle_count = 0;
	int            slots_in_use = 0;

	int unsigned   idle_left = 0;
	int unsigned   burst_left = 0;
	int unsigned   stall_mode = 0;
	int unsigned   mode_left = 0;
	int unsigned   stall_tick = 0;

	linear_probe_layout_table u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.type_key       (type_key),
		.object_size    (object_size),
		.pointer_total  (pointer_total),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.found_size     (found_size),
		.found_pointers (found_pointers)
	);

	always #5 clk = ~clk;

	// Walks the shadow table exactly as the block probes its slot memory.
	function automatic layout_reply_t resolve_layout(layout_req_t req);
		layout_reply_t    reply;
		int unsigned      slot;
		int               probe;
		logic [PTR_W-1:0] kept;
		reply = '{ST_RESERVED, '0, '0};
		if (req.key == '0)
			return reply;
		slot = int'(req.key % KEY_W'(TABLE_SLOTS));
		kept = (req.ptot > MAX_PTRS) ? PTR_W'(MAX_PTRS) : PTR_W'(req.ptot);
		for (probe = 0; probe < TABLE_SLOTS; probe++) begin
			if (shadow_key[slot] == '0) begin
				if (req.act == ACT_INSERT) begin
					shadow_key[slot]  = req.key;
					shadow_size[slot] = req.size;
					shadow_ptrs[slot] = kept;
					reply.status = ST_INSERTED;
				end else begin
					reply.status = ST_NOT_FOUND;
				end
				return reply;
			end
			if (shadow_key[slot] == req.key) begin
				if (req.act == ACT_INSERT) begin
					shadow_size[slot] = req.size;
					shadow_ptrs[slot] = kept;
					reply.status = ST_UPDATED;
				end else begin
					reply.status = ST_FOUND;
					reply.size   = shadow_size[slot];
					reply.ptrs   = shadow_ptrs[slot];
				end
				return reply;
			end
			slot = (slot + 1) % TABLE_SLOTS;
		end
		if (req.act == ACT_INSERT)
			reply.status = ST_FULL;
		else
			reply.status = ST_NOT_FOUND;
		return reply;
	endfunction

	function automatic logic [KEY_W-1:0] fresh_key(int unsigned home);
		logic [KEY_W-1:0] k;
		do begin
			k = {$urandom, $urandom};
			k[SLOT_W-1:0] = SLOT_W'(home);
		end while (k == '0 || keys_used.exists(k));
		keys_used[k] = 1'b1;
		return k;
	endfunction

	// Half the homes crowd round the wrap point so that chains grow long and wrap.
	function automatic int unsigned pick_home();
		if ($urandom_range(0, 1) == 1)
			return (990 + $urandom_range(0, 63)) % TABLE_SLOTS;
		return $urandom_range(0, TABLE_SLOTS - 1);
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [PTRT_W-1:0] pick_ptot();
		if ($urandom_range(0, 1) == 1)
			return PTRT_W'($urandom_range(0, 20));
		return PTRT_W'($urandom);
	endfunction

	task automatic queue_beat(action_t act, logic [KEY_W-1:0] key, logic [SIZE_W-1:0] size,
			logic [PTRT_W-1:0] ptot);
		pending.push_back('{act, key, size, ptot, 1'b0});
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending.size() != 0 || in_valid || beats_loaded != results_seen)
			@(negedge clk);
	endtask

	// Sender: bursts of beats with idle gaps; a hold marker waits for every result.
	always @(posedge clk or negedge arst_n) begin
		layout_req_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (idle_left != 0) begin
				in_valid  <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (pending.size() == 0) begin
				in_valid <= 1'b0;
			end else if (pending[0].hold) begin
				in_valid <= 1'b0;
				if (beats_loaded == results_seen)
					void'(pending.pop_front());
			end else begin
				req = pending.pop_front();
				in_valid      <= 1'b1;
				action        <= req.act;
				type_key      <= req.key;
				object_size   <= req.size;
				pointer_total <= req.ptot;
				replies_due.push_back(resolve_layout(req));
				beats_loaded <= beats_loaded + 1;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 30);
					idle_left  <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver: checks each result beat and stalls in changing patterns.
	always @(posedge clk or negedge arst_n) begin
		layout_reply_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (!$isunknown(status) && status <= 3'(ST_RESERVED))
					status_hits[status]++;
				if (replies_due.size() == 0) begin
					$display("%0t: result with none expected, got status %0d", $time, status);
					fail_count++;
				end else begin
					want = replies_due.pop_front();
					if (status !== 3'(want.status)) begin
						$display("%0t: status expected %0d, got %0d", $time, want.status, status);
						fail_count++;
					end
					if (found_size !== want.size) begin
						$display("%0t: found_size expected %0h, got %0h", $time, want.size,
							found_size);
						fail_count++;
					end
					if (found_pointers !== want.ptrs) begin
						$display("%0t: found_pointers expected %0d, got %0d", $time, want.ptrs,
							found_pointers);
						fail_count++;
					end
				end
			end
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left  <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			stall_tick <= stall_tick + 1;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 1) == 1);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (stall_tick % 5) < 2;
			endcase
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic [KEY_W-1:0] pool [POOL_KEYS];
		logic [KEY_W-1:0] key;
		int unsigned      pick;
		int unsigned      start;
		int unsigned      s;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reserved key, empty lookups, wrap-around collisions, clamping and updates.
		queue_beat(ACT_LOOKUP, '0, '1, '1);
		queue_beat(ACT_INSERT, '0, '1, '1);
		queue_beat(ACT_LOOKUP, 64'd5, '0, '0);
		queue_beat(ACT_INSERT, '1, '1, '1);
		queue_beat(ACT_LOOKUP, '1, '0, '0);
		queue_beat(ACT_INSERT, 64'h7FF, 32'hDEAD_BEEF, 16'd3);
		queue_beat(ACT_INSERT, 64'h400, 32'h0000_0001, 16'd16);
		queue_beat(ACT_LOOKUP, 64'h7FF, '0, '0);
		queue_beat(ACT_LOOKUP, 64'h400, '0, '0);
		queue_beat(ACT_INSERT, 64'd1, '0, '0);
		queue_beat(ACT_LOOKUP, 64'd1, '1, '1);
		queue_beat(ACT_INSERT, 64'h400, 32'h1234_5678, 16'd17);
		queue_beat(ACT_LOOKUP, 64'h400, '0, '0);
		queue_beat(ACT_INSERT, 64'h400, 32'hFFFF_0000, 16'd15);
		queue_beat(ACT_LOOKUP, 64'h400, '0, '0);
		queue_beat(ACT_LOOKUP, 64'hC00, '0, '0);
		queue_beat(ACT_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000, 16'd16);
		queue_beat(ACT_LOOKUP, 64'h8000_0000_0000_0000, '0, '0);
		queue_beat(ACT_INSERT, 64'd1, 32'h8000_0000, 16'd1);
		queue_beat(ACT_LOOKUP, 64'd1, '0, '0);
		queue_beat(ACT_LOOKUP, 64'hBFF, '0, '0);

		foreach (pool[i])
			pool[i] = fresh_key(pick_home());
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			pick = $urandom_range(0, 99);
			key  = pool[$urandom_range(0, POOL_KEYS - 1)];
			if (pick < 42)
				queue_beat(ACT_INSERT, key, pick_size(), pick_ptot());
			else if (pick < 80)
				queue_beat(ACT_LOOKUP, key, pick_size(), pick_ptot());
			else if (pick < 94)
				queue_beat(ACT_LOOKUP, fresh_key(pick_home()), pick_size(), pick_ptot());
			else
				queue_beat(action_t'($urandom_range(0, 1)), '0, pick_size(), pick_ptot());
			if (i % 500 == 499)
				pending.push_back('{ACT_LOOKUP, '0, '0, '0, 1'b1});
		end
		wait_idle();

		// Each remaining empty slot gets a key whose home is that slot.
		start = $urandom_range(0, TABLE_SLOTS - 1);
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			s = (start + i) % TABLE_SLOTS;
			if (shadow_key[s] == '0)
				queue_beat(ACT_INSERT, fresh_key(s), pick_size(), pick_ptot());
		end
		wait_idle();
		foreach (shadow_key[i])
			if (shadow_key[i] != '0)
				slots_in_use++;

		for (int i = 0; i < FULL_BEATS; i++) begin
			key = shadow_key[$urandom_range(0, TABLE_SLOTS - 1)];
			case ($urandom_range(0, 4))
				0: queue_beat(ACT_INSERT, fresh_key(pick_home()), pick_size(), pick_ptot());
				1: queue_beat(ACT_LOOKUP, fresh_key(pick_home()), pick_size(), pick_ptot());
				2: queue_beat(ACT_INSERT, key, pick_size(), pick_ptot());
				3: queue_beat(ACT_LOOKUP, key, pick_size(), pick_ptot());
				default: queue_beat(action_t'($urandom_range(0, 1)), '0, '0, '0);
			endcase
		end
		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (replies_due.size() != 0) begin
			$display("%0t: %0d results expected but never seen", $time, replies_due.size());
			fail_count++;
		end
		$display("Checked %0d beats: %0d inserted, %0d updated, %0d found, %0d not found,",
			results_seen, status_hits[ST_INSERTED], status_hits[ST_UPDATED],
			status_hits[ST_FOUND], status_hits[ST_NOT_FOUND]);
		$display("%0d full, %0d reserved; the table reached %0d of %0d slots in use.",
			status_hits[ST_FULL], status_hits[ST_RESERVED], slots_in_use, TABLE_SLOTS);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> linear_probe_layout_table.f
rtl/lplt_pkg.sv
rtl/lplt_slot_ram.sv
rtl/lplt_probe_ctrl.sv
rtl/linear_probe_layout_table.sv
dv/testbench.sv
